// ----- sv/mtfve_pkg.sv -----
package mtfve_pkg;

	localparam int TABLE_DEPTH = 4096;
	localparam int POS_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int SYM_W = 12;
	localparam int ALPH_W = 13;
	localparam logic [ALPH_W-1:0] ALPH_RESET = 13'd4096;

	localparam int VAR_W = 21;
	localparam logic [VAR_W-1:0] ONE_BYTE_LIMIT = 21'd128;
	localparam logic [VAR_W-1:0] TWO_BYTE_LIMIT = 21'd16384;
	localparam logic [7:0] CONT_BIT = 8'h80;
	localparam logic [6:0] PAYLOAD_MASK = 7'h7F;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             final_req;
	} in_item_t;

	typedef struct packed {
		logic [7:0] code_byte;
		logic       last_byte;
		logic       bad_symbol;
	} out_item_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             final_req;
		logic             bad;
	} job_t;

	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic             bad;
	} code_t;

	function automatic logic [POS_W-1:0] sym_to_pos(input logic [SYM_W-1:0] sym);
		logic [SYM_W+POS_W-1:0] w;
		w = {{POS_W{1'b0}}, sym};
		return w[POS_W-1:0];
	endfunction

endpackage

// ----- sv/mtfve_fifo.sv -----
module mtfve_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  mtfve_pkg::job_t    push_data,
	input  logic               pop,
	output mtfve_pkg::job_t    head,
	output logic               not_empty,
	output logic               full
);

	mtfve_pkg::job_t slot_q [mtfve_pkg::FIFO_DEPTH];
	logic [mtfve_pkg::FIFO_AW-1:0] wr_ptr_q;
	logic [mtfve_pkg::FIFO_AW-1:0] rd_ptr_q;
	logic [mtfve_pkg::FIFO_CW-1:0] count_q;

	assign head = slot_q[rd_ptr_q];
	assign not_empty = count_q != '0;
	assign full = count_q == mtfve_pkg::FIFO_CW'(mtfve_pkg::FIFO_DEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + mtfve_pkg::FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + mtfve_pkg::FIFO_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + mtfve_pkg::FIFO_CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - mtfve_pkg::FIFO_CW'(1);
			end
		end
	end

endmodule

// ----- sv/mtfve_front.sv -----
module mtfve_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mtfve_pkg::ALPH_W-1:0]    cfg_data,
	input  logic                            sym_valid,
	output logic                            sym_stall,
	input  mtfve_pkg::in_item_t             sym_item,
	output logic                            job_valid,
	output mtfve_pkg::job_t                 job,
	input  logic                            job_pop
);

	logic [mtfve_pkg::ALPH_W-1:0] alph_q;
	logic                         full;
	logic                         push;
	mtfve_pkg::job_t              push_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alph_q <= mtfve_pkg::ALPH_RESET;
		end else if (cfg_we) begin
			alph_q <= cfg_data;
		end
	end

	always_comb begin
		push_data.symbol = sym_item.symbol;
		push_data.final_req = sym_item.final_req;
		push_data.bad = ({1'b0, sym_item.symbol} >= alph_q) ||
			(32'(sym_item.symbol) >= 32'(mtfve_pkg::TABLE_DEPTH));
	end

	assign sym_stall = full;
	assign push = sym_valid && !full;

	mtfve_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (job_pop),
		.head      (job),
		.not_empty (job_valid),
		.full      (full)
	);

endmodule

// ----- sv/mtfve_back.sv -----
module mtfve_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               job_valid,
	input  mtfve_pkg::job_t    job,
	output logic               job_pop,
	output logic               code_valid,
	output mtfve_pkg::code_t   code,
	input  logic               code_ready
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_WALK = 1'b1;

	// Positions at or beyond the high-water mark count as unmoved and read as their own index.
	logic [mtfve_pkg::POS_W-1:0] mem [mtfve_pkg::TABLE_DEPTH];

	logic                         state_q;
	logic [mtfve_pkg::POS_W-1:0]  rd_data_q;
	logic [mtfve_pkg::POS_W-1:0]  carry_q;
	logic [mtfve_pkg::POS_W-1:0]  cur_q;
	logic [mtfve_pkg::POS_W-1:0]  sym_pos_q;
	logic                         final_q;
	logic [mtfve_pkg::CNT_W-1:0]  hw_q;
	logic                         code_vld_q;
	mtfve_pkg::code_t             code_q;

	logic [mtfve_pkg::POS_W-1:0]  rd_addr;
	logic [mtfve_pkg::POS_W-1:0]  value;
	logic [mtfve_pkg::CNT_W-1:0]  cur_ext;
	logic [mtfve_pkg::CNT_W-1:0]  next_ext;
	logic                         code_free;
	logic                         hit;
	logic                         walk_go;

	assign code_free = !code_vld_q || code_ready;
	assign cur_ext = mtfve_pkg::CNT_W'(cur_q);
	assign next_ext = cur_ext + mtfve_pkg::CNT_W'(1);
	assign value = (cur_ext < hw_q) ? rd_data_q : cur_q;
	assign hit = value == sym_pos_q;
	assign walk_go = (state_q == ST_WALK) && (!hit || code_free);
	assign job_pop = (state_q == ST_IDLE) && job_valid && (!job.bad || code_free);
	assign code_valid = code_vld_q;
	assign code = code_q;

	always_comb begin
		if (state_q == ST_IDLE) begin
			rd_addr = '0;
		end else if (walk_go) begin
			rd_addr = cur_q + mtfve_pkg::POS_W'(1);
		end else begin
			rd_addr = cur_q;
		end
	end

	always_ff @(posedge clk) begin
		if (walk_go) begin
			mem[cur_q] <= carry_q;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hw_q <= '0;
			code_vld_q <= 1'b0;
			code_q <= '0;
			carry_q <= '0;
			cur_q <= '0;
			sym_pos_q <= '0;
			final_q <= 1'b0;
		end else begin
			if (code_vld_q && code_ready) begin
				code_vld_q <= 1'b0;
			end
			if (cfg_we) begin
				hw_q <= '0;
			end
			case (state_q)
				ST_IDLE: begin
					if (job_pop) begin
						if (job.bad) begin
							code_vld_q <= 1'b1;
							code_q.pos <= '0;
							code_q.bad <= 1'b1;
							if (job.final_req) begin
								hw_q <= '0;
							end
						end else begin
							state_q <= ST_WALK;
							cur_q <= '0;
							carry_q <= mtfve_pkg::sym_to_pos(job.symbol);
							sym_pos_q <= mtfve_pkg::sym_to_pos(job.symbol);
							final_q <= job.final_req;
						end
					end
				end
				ST_WALK: begin
					if (walk_go) begin
						carry_q <= value;
						if (hit) begin
							state_q <= ST_IDLE;
							code_vld_q <= 1'b1;
							code_q.pos <= cur_q;
							code_q.bad <= 1'b0;
							if (final_q) begin
								hw_q <= '0;
							end else if (next_ext > hw_q) begin
								hw_q <= next_ext;
							end
						end else begin
							cur_q <= cur_q + mtfve_pkg::POS_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- sv/mtfve_emit.sv -----
module mtfve_emit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  code_valid,
	input  mtfve_pkg::code_t      code,
	output logic                  code_ready,
	output logic                  out_valid,
	output mtfve_pkg::out_item_t  out_item,
	input  logic                  out_stall
);

	logic                         busy_q;
	logic [mtfve_pkg::VAR_W-1:0]  pos_x_q;
	logic                         bad_q;
	logic [1:0]                   left_q;
	logic                         out_vld_q;
	mtfve_pkg::out_item_t         out_q;

	logic [mtfve_pkg::VAR_W-1:0]  load_pos;
	logic [1:0]                   load_len;
	logic                         out_free;
	mtfve_pkg::out_item_t         next_byte;

	assign code_ready = !busy_q;
	assign out_free = !out_vld_q || !out_stall;
	assign out_valid = out_vld_q;
	assign out_item = out_q;
	assign load_pos = code.bad ? '0 : mtfve_pkg::VAR_W'(code.pos);

	always_comb begin
		if (code.bad || (load_pos < mtfve_pkg::ONE_BYTE_LIMIT)) begin
			load_len = 2'd1;
		end else if (load_pos < mtfve_pkg::TWO_BYTE_LIMIT) begin
			load_len = 2'd2;
		end else begin
			load_len = 2'd3;
		end
	end

	always_comb begin
		case (left_q)
			2'd3: begin
				next_byte.code_byte = mtfve_pkg::CONT_BIT | {1'b0, pos_x_q[20:14]};
				next_byte.last_byte = 1'b0;
				next_byte.bad_symbol = 1'b0;
			end
			2'd2: begin
				next_byte.code_byte = mtfve_pkg::CONT_BIT | {1'b0, pos_x_q[13:7]};
				next_byte.last_byte = 1'b0;
				next_byte.bad_symbol = 1'b0;
			end
			default: begin
				next_byte.code_byte = {1'b0, pos_x_q[6:0] & mtfve_pkg::PAYLOAD_MASK};
				next_byte.last_byte = 1'b1;
				next_byte.bad_symbol = bad_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_x_q <= '0;
			bad_q <= 1'b0;
			left_q <= '0;
			out_vld_q <= 1'b0;
			out_q <= '0;
		end else begin
			if (code_valid && !busy_q) begin
				busy_q <= 1'b1;
				pos_x_q <= load_pos;
				bad_q <= code.bad;
				left_q <= load_len;
			end
			if (out_free) begin
				if (busy_q) begin
					out_vld_q <= 1'b1;
					out_q <= next_byte;
					left_q <= left_q - 2'd1;
					if (left_q == 2'd1) begin
						busy_q <= 1'b0;
					end
				end else begin
					out_vld_q <= 1'b0;
				end
			end
		end
	end

endmodule

// ----- sv/move_to_front_varint_encoder.sv -----
// Move-to-front coder with big-endian varint output. Each symbol transaction is classified
// against the alphabet size and queued; a list walker then reads and rewrites the recency
// list one position per cycle through a memory with one read and one write port. At the
// found position, and for an out-of-range symbol, it waits until the byte emitter has taken
// the previous position. The resulting position leaves as one to three bytes, one byte per
// cycle unless the output stalls, while the walker already works on the next symbol. No
// clearing pass is needed after reset, after a final symbol or after a write of
// alphabet_size: list positions beyond the highest one moved since then read as their own
// index. Write alphabet_size only while no symbol is in flight.
module move_to_front_varint_encoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mtfve_pkg::ALPH_W-1:0]  cfg_data,
	input  logic                          sym_valid,
	output logic                          sym_stall,
	input  mtfve_pkg::in_item_t           sym_item,
	output logic                          code_valid,
	input  logic                          code_stall,
	output mtfve_pkg::out_item_t          code_item
);

	logic             job_valid;
	mtfve_pkg::job_t  job;
	logic             job_pop;
	logic             pos_valid;
	mtfve_pkg::code_t pos_code;
	logic             pos_ready;

	mtfve_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.sym_valid (sym_valid),
		.sym_stall (sym_stall),
		.sym_item  (sym_item),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop)
	);

	mtfve_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.job_valid  (job_valid),
		.job        (job),
		.job_pop    (job_pop),
		.code_valid (pos_valid),
		.code       (pos_code),
		.code_ready (pos_ready)
	);

	mtfve_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.code_valid (pos_valid),
		.code       (pos_code),
		.code_ready (pos_ready),
		.out_valid  (code_valid),
		.out_item   (code_item),
		.out_stall  (code_stall)
	);

endmodule

// ----- sv/mtfve_chk.sv -----
module mtfve_chk (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  code_valid,
	input logic                  code_stall,
	input mtfve_pkg::out_item_t  code_item
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid && code_stall |=> code_valid)
		else $error("Stalled result transaction was withdrawn.");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid && code_stall |=> $stable(code_item))
		else $error("Stalled result transaction changed.");

	a_bad_form: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid && code_item.bad_symbol |->
			code_item.last_byte && (code_item.code_byte == 8'h00))
		else $error("Error result is not a single zero byte.");

	a_cont_bit: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid |-> (code_item.code_byte[7] == !code_item.last_byte))
		else $error("Continuation bit disagrees with the last-byte flag.");

	a_after_mid: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid && !code_stall && !code_item.last_byte ##1 code_valid |->
			!code_item.bad_symbol)
		else $error("Error result appeared inside a multi-byte code.");

endmodule

bind move_to_front_varint_encoder mtfve_chk u_mtfve_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.code_valid (code_valid),
	.code_stall (code_stall),
	.code_item  (code_item)
);

// ----- sim/tb_move_to_front_varint_encoder.sv -----
`timescale 1ns / 1ps

module tb_move_to_front_varint_encoder;
	import mtfve_pkg::*;

	localparam int WATCHDOG_LIMIT = 40000;
	localparam int CFG_PAUSE = 16;
	localparam int END_TAIL = 200;
	localparam int REPORT_MAX = 10;

	class mtf_code_tracker;
		logic [SYM_W-1:0] order [TABLE_DEPTH];
		logic [ALPH_W-1:0] alphabet;
		out_item_t pending_bytes [$];
		int mismatches;

		function new();
			alphabet = ALPH_RESET;
			mismatches = 0;
			restore_order();
		endfunction

		function void restore_order();
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				order[i] = SYM_W'(i);
			end
		endfunction

		function void set_alphabet(logic [ALPH_W-1:0] value);
			alphabet = value;
			restore_order();
		endfunction

		function int outstanding();
			return pending_bytes.size();
		endfunction

		function void push_byte(logic [7:0] code, logic last, logic bad);
			out_item_t r;
			r.code_byte = code;
			r.last_byte = last;
			r.bad_symbol = bad;
			pending_bytes.push_back(r);
		endfunction

		function void note_symbol(in_item_t it);
			int span;
			int pos;
			bit hit;
			span = (alphabet > TABLE_DEPTH) ? TABLE_DEPTH : int'(alphabet);
			hit = 1'b0;
			pos = 0;
			if (int'(it.symbol) < span) begin
				for (int p = 0; p < span && !hit; p++) begin
					if (order[p] == it.symbol) begin
						hit = 1'b1;
						pos = p;
					end
				end
			end
			if (!hit) begin
				push_byte(8'h00, 1'b1, 1'b1);
			end else if (pos < int'(ONE_BYTE_LIMIT)) begin
				push_byte(8'(pos), 1'b1, 1'b0);
			end else if (pos < int'(TWO_BYTE_LIMIT)) begin
				push_byte(CONT_BIT | {1'b0, 7'(pos >> 7) & PAYLOAD_MASK}, 1'b0, 1'b0);
				push_byte({1'b0, 7'(pos) & PAYLOAD_MASK}, 1'b1, 1'b0);
			end else begin
				push_byte(CONT_BIT | {1'b0, 7'(pos >> 14) & PAYLOAD_MASK}, 1'b0, 1'b0);
				push_byte(CONT_BIT | {1'b0, 7'(pos >> 7) & PAYLOAD_MASK}, 1'b0, 1'b0);
				push_byte({1'b0, 7'(pos) & PAYLOAD_MASK}, 1'b1, 1'b0);
			end
			if (hit) begin
				for (int k = pos; k > 0; k--) begin
					order[k] = order[k-1];
				end
				order[0] = it.symbol;
			end
			if (it.final_req) begin
				restore_order();
			end
		endfunction

		function void check_byte(out_item_t got);
			out_item_t want;
			if (pending_bytes.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$display("code byte with no symbol pending: byte %02h last %b bad %b",
						got.code_byte, got.last_byte, got.bad_symbol);
				end
			end else begin
				want = pending_bytes.pop_front();
				if (got.code_byte !== want.code_byte || got.last_byte !== want.last_byte ||
					got.bad_symbol !== want.bad_symbol) begin
					mismatches++;
					if (mismatches <= REPORT_MAX) begin
						$display("code byte mismatch: expected %02h/%b/%b, got %02h/%b/%b",
							want.code_byte, want.last_byte, want.bad_symbol,
							got.code_byte, got.last_byte, got.bad_symbol);
					end
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [ALPH_W-1:0] cfg_data = '0;
	logic sym_valid = 1'b0;
	logic sym_stall;
	in_item_t sym_item = '0;
	logic code_valid;
	logic code_stall = 1'b0;
	out_item_t code_item;

	mtf_code_tracker tracker = new();
	int sent_count = 0;
	int got_count = 0;
	bit in_burst = 1'b0;
	bit out_burst = 1'b0;

	move_to_front_varint_encoder i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.sym_valid(sym_valid),
		.sym_stall(sym_stall),
		.sym_item(sym_item),
		.code_valid(code_valid),
		.code_stall(code_stall),
		.code_item(code_item)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic send_symbol(logic [SYM_W-1:0] sym, logic fin);
		in_item_t it;
		int gap;
		it.symbol = sym;
		it.final_req = fin;
		if (sent_count % 32 == 0) begin
			in_burst = ($urandom_range(0, 3) == 0);
		end
		gap = in_burst ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			sym_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sym_valid <= 1'b1;
		sym_item <= it;
		@(posedge clk);
		while (sym_stall !== 1'b0) @(posedge clk);
		tracker.note_symbol(it);
		sent_count++;
	endtask

	task automatic write_alphabet(logic [ALPH_W-1:0] value);
		sym_valid <= 1'b0;
		while (tracker.outstanding() != 0) @(posedge clk);
		repeat (CFG_PAUSE) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.set_alphabet(value);
	endtask

	task automatic random_phase(logic [ALPH_W-1:0] value, int count);
		int span;
		int roll;
		logic [SYM_W-1:0] sym;
		logic [SYM_W-1:0] recent [$];
		write_alphabet(value);
		span = (value > TABLE_DEPTH) ? TABLE_DEPTH : int'(value);
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			if (span == 0 || (roll < 15 && span < TABLE_DEPTH)) begin
				sym = SYM_W'($urandom_range(span, TABLE_DEPTH - 1));
			end else if (roll < 40 && recent.size() > 0) begin
				sym = recent[$urandom_range(0, recent.size() - 1)];
			end else begin
				sym = SYM_W'($urandom_range(0, span - 1));
			end
			if (int'(sym) < span) begin
				recent.push_back(sym);
				if (recent.size() > 8) begin
					void'(recent.pop_front());
				end
			end
			send_symbol(sym, $urandom_range(0, 99) < 8);
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_symbol(12'd0, 1'b0);
		send_symbol(12'd4095, 1'b0);
		send_symbol(12'd4095, 1'b0);
		send_symbol(12'd127, 1'b0);
		send_symbol(12'd128, 1'b0);
		send_symbol(12'd2000, 1'b1);
		send_symbol(12'd127, 1'b0);
		send_symbol(12'd128, 1'b1);
		write_alphabet(13'd0);
		send_symbol(12'd0, 1'b0);
		send_symbol(12'd4095, 1'b1);
		write_alphabet(13'd1);
		send_symbol(12'd0, 1'b0);
		send_symbol(12'd1, 1'b0);
		send_symbol(12'd4095, 1'b1);
		send_symbol(12'd0, 1'b0);
		write_alphabet(13'd8191);
		send_symbol(12'd4095, 1'b0);
		send_symbol(12'd0, 1'b0);
		send_symbol(12'd5, 1'b1);
		send_symbol(12'd2730, 1'b0);

		random_phase(13'd16, 60);
		random_phase(13'd200, 60);
		random_phase(13'd1, 25);
		random_phase(13'd129, 50);
		random_phase(13'd4096, 20);
		random_phase(ALPH_W'($urandom_range(2, 300)), 60);
		random_phase(13'd0, 10);
		random_phase(13'd8191, 15);
		random_phase(ALPH_W'($urandom_range(300, 1000)), 40);
		random_phase(13'd64, 70);

		sym_valid <= 1'b0;
		while (tracker.outstanding() != 0) @(posedge clk);
		repeat (END_TAIL) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
			$display("tb_move_to_front_varint_encoder: clean");
		end else begin
			$display("tb_move_to_front_varint_encoder: errors");
		end
		$finish;
	end

	initial begin
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			if (got_count % 32 == 0) begin
				out_burst = ($urandom_range(0, 3) == 0);
			end
			gap = out_burst ? 0 : $urandom_range(0, 5);
			if (gap > 0) begin
				code_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			code_stall <= 1'b0;
			@(posedge clk);
			while (code_valid !== 1'b1) @(posedge clk);
			tracker.check_byte(code_item);
			got_count++;
		end
	end

	initial begin
		int idle;
		idle = 0;
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((sym_valid && sym_stall === 1'b0) || (code_valid === 1'b1 && !code_stall)) begin
				idle = 0;
			end else begin
				idle++;
			end
		end
		$display("tb_move_to_front_varint_encoder: errors");
		$finish;
	end

endmodule
